FILE: hw/rtl/http_request_header_parser_unit_macros.svh
// Assertion helpers for the request parser.
`ifndef HTTP_REQUEST_HEADER_PARSER_UNIT_MACROS_SVH
`define HTTP_REQUEST_HEADER_PARSER_UNIT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define HRP_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Implication whose consequent is checked in the cycle after the antecedent.
`define HRP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

FILE: hw/rtl/hrp_pkg.sv
package hrp_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned PosW = 16;
  localparam int unsigned OutLenW = 32;

  typedef enum logic [1:0] {
    ST_MORE = 2'd0,
    ST_BAD  = 2'd1,
    ST_OK   = 2'd2,
    ST_OVER = 2'd3
  } status_t;

  // One queued byte together with the front's classification.
  typedef struct packed {
    logic [ByteW-1:0] ch;
    logic             restart;
    logic             is_gap;
    logic             is_digit;
    logic             is_cr;
    logic             is_lf;
  } byte_item_t;

  localparam int unsigned ItemW = $bits(byte_item_t);

  function automatic logic [ByteW-1:0] to_lower(input logic [ByteW-1:0] c);
    if (c >= 8'h41 && c <= 8'h5A) begin
      return c + 8'd32;
    end
    return c;
  endfunction

  function automatic logic [ByteW-1:0] kw_get_chr(input logic [3:0] i);
    logic [ByteW-1:0] r;
    unique case (i)
      4'd0: r = "g";
      4'd1: r = "e";
      4'd2: r = "t";
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [ByteW-1:0] kw_ver_chr(input logic [3:0] i);
    logic [ByteW-1:0] r;
    unique case (i)
      4'd0: r = "h";
      4'd1: r = "t";
      4'd2: r = "t";
      4'd3: r = "p";
      4'd4: r = "/";
      4'd5: r = "1";
      4'd6: r = ".";
      4'd7: r = "1";
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [ByteW-1:0] kw_scheme_chr(input logic [3:0] i);
    logic [ByteW-1:0] r;
    unique case (i)
      4'd0: r = "h";
      4'd1: r = "t";
      4'd2: r = "t";
      4'd3: r = "p";
      4'd4: r = ":";
      4'd5: r = "/";
      4'd6: r = "/";
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [ByteW-1:0] kw_keep_chr(input logic [3:0] i);
    logic [ByteW-1:0] r;
    unique case (i)
      4'd0: r = "k";
      4'd1: r = "e";
      4'd2: r = "e";
      4'd3: r = "p";
      4'd4: r = "-";
      4'd5: r = "a";
      4'd6: r = "l";
      4'd7: r = "i";
      4'd8: r = "v";
      4'd9: r = "e";
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  // Header name tables, kind 1 connection, 2 content-length, 3 host.
  function automatic logic [ByteW-1:0] hdr_chr(input logic [1:0] k, input logic [3:0] i);
    logic [ByteW-1:0] r;
    r = 8'h00;
    unique case (k)
      2'd1: begin
        unique case (i)
          4'd0: r = "c";  4'd1: r = "o";  4'd2: r = "n";  4'd3: r = "n";
          4'd4: r = "e";  4'd5: r = "c";  4'd6: r = "t";  4'd7: r = "i";
          4'd8: r = "o";  4'd9: r = "n";  4'd10: r = ":";
          default: r = 8'h00;
        endcase
      end
      2'd2: begin
        unique case (i)
          4'd0: r = "c";  4'd1: r = "o";  4'd2: r = "n";  4'd3: r = "t";
          4'd4: r = "e";  4'd5: r = "n";  4'd6: r = "t";  4'd7: r = "-";
          4'd8: r = "l";  4'd9: r = "e";  4'd10: r = "n"; 4'd11: r = "g";
          4'd12: r = "t"; 4'd13: r = "h"; 4'd14: r = ":";
          default: r = 8'h00;
        endcase
      end
      2'd3: begin
        unique case (i)
          4'd0: r = "h";  4'd1: r = "o";  4'd2: r = "s";  4'd3: r = "t";
          4'd4: r = ":";
          default: r = 8'h00;
        endcase
      end
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [4:0] hdr_len(input logic [1:0] k);
    logic [4:0] r;
    unique case (k)
      2'd1: r = 5'd11;
      2'd2: r = 5'd15;
      2'd3: r = 5'd5;
      default: r = 5'd0;
    endcase
    return r;
  endfunction

endpackage

FILE: hw/rtl/hrp_front.sv
module hrp_front
  import hrp_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [ByteW-1:0] in_ch,
  input  logic             in_restart,
  output logic             item_valid,
  input  logic             item_ready,
  output byte_item_t       item
);

  byte_item_t item_r;
  logic       item_valid_r;
  byte_item_t cls;

  always_comb begin
    cls.ch       = in_ch;
    cls.restart  = in_restart;
    cls.is_gap   = (in_ch == 8'h20) || (in_ch == 8'h09);
    cls.is_digit = (in_ch >= 8'h30) && (in_ch <= 8'h39);
    cls.is_cr    = (in_ch == 8'h0D);
    cls.is_lf    = (in_ch == 8'h0A);
  end

  assign in_ready   = !item_valid_r || item_ready;
  assign item_valid = item_valid_r;
  assign item       = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else if (in_ready) begin
      item_valid_r <= in_valid;
    end
    if (in_ready && in_valid) begin
      item_r <= cls;
    end
  end

endmodule

FILE: hw/rtl/hrp_queue.sv
module hrp_queue
  import hrp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       wr_valid,
  output logic       wr_ready,
  input  byte_item_t wr_item,
  output logic       rd_valid,
  input  logic       rd_ready,
  output byte_item_t rd_item
);

  // Two-entry queue; both slots read at fixed places.
  byte_item_t slot_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       push, pop;

  assign wr_ready = (cnt_r != 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_item  = rp_r ? slot_r[1] : slot_r[0];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= !wp_r;
      if (pop)  rp_r <= !rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
    if (push) begin
      if (wp_r) slot_r[1] <= wr_item;
      else      slot_r[0] <= wr_item;
    end
  end

endmodule

FILE: hw/rtl/hrp_back.sv
module hrp_back
  import hrp_pkg::*;
#(
  parameter int unsigned REQUEST_BUFFER_BYTES = 2048,
  parameter int unsigned LENGTH_BITS = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [PosW-1:0]     max_bytes,
  input  logic                item_valid,
  output logic                item_ready,
  input  byte_item_t          item,
  output logic                res_valid,
  input  logic                res_ready,
  output logic [1:0]          res_status,
  output logic                res_keep,
  output logic [OutLenW-1:0]  res_length,
  output logic [PosW-1:0]     res_offset,
  output logic [PosW-1:0]     res_size
);

  typedef enum logic [3:0] {
    PH_METHOD, PH_GAP1, PH_PREFIX, PH_HOST, PH_PATH, PH_GAP2, PH_VERSION, PH_FAIL,
    PH_HNAME, PH_HSKIP, PH_CGAP, PH_CVAL, PH_LGAP, PH_LDIG, PH_BODY, PH_DONE
  } phase_t;

  localparam int unsigned LenW = LENGTH_BITS;
  localparam logic [LenW-1:0] LenLimit = (LENGTH_BITS >= 32) ?
      LenW'(64'hFFFF_FFFF) : {LenW{1'b1}};
  localparam logic [PosW-1:0] BufBytes = PosW'(REQUEST_BUFFER_BYTES);
  // Above this value times ten plus a digit may pass the limit.
  localparam logic [LenW-1:0] LenTen = LenLimit / 10;
  localparam logic [3:0] LenRem = 4'(LenLimit % 10);

  phase_t          ph_r, ph_nxt;
  logic [3:0]      mi_r, mi_nxt;
  logic [1:0]      hk_r, hk_nxt;
  logic            cr_r, cr_nxt;
  logic [PosW-1:0] seen_r, seen_nxt;
  logic [LenW-1:0] len_r, len_nxt;
  logic [LenW-1:0] rem_r, rem_nxt;
  logic            keep_r, keep_nxt;
  logic [PosW-1:0] ps_r, ps_nxt;
  logic [PosW-1:0] pz_r, pz_nxt;
  logic            res_valid_r;
  logic [1:0]      st_r;
  logic            kp_r;
  logic [LenW-1:0] lo_r;
  logic [PosW-1:0] of_r, sz_r;

  logic [PosW-1:0] limit;
  logic            take;
  logic [ByteW-1:0] c, lc;
  logic [LenW+3:0] len_x10;
  logic [3:0]      dig;
  logic [4:0]      hl;

  assign limit      = (max_bytes < BufBytes) ? max_bytes : BufBytes;
  assign item_ready = !res_valid_r || res_ready;
  assign take       = item_valid && item_ready;
  assign c          = item.ch;
  assign lc         = to_lower(item.ch);
  assign dig        = item.ch[3:0];
  assign len_x10    = {len_r, 3'b000} + {2'b00, len_r, 1'b0} + (LenW+4)'(dig);

  always_comb begin
    logic [3:0] k;
    ph_nxt   = ph_r;   mi_nxt = mi_r;   hk_nxt = hk_r;   cr_nxt = cr_r;
    seen_nxt = seen_r; len_nxt = len_r; rem_nxt = rem_r; keep_nxt = keep_r;
    ps_nxt   = ps_r;   pz_nxt = pz_r;
    hl = 5'd0;
    k  = 4'd0;
    if (item.restart) begin
      ph_nxt = PH_METHOD; mi_nxt = '0; hk_nxt = '0; cr_nxt = 1'b0; seen_nxt = '0;
      len_nxt = '0; rem_nxt = '0; keep_nxt = 1'b0; ps_nxt = '0; pz_nxt = '0;
    end
    if (ph_nxt != PH_DONE) begin
      if (seen_nxt >= limit) begin
        ph_nxt = PH_DONE; hk_nxt = ST_OVER;
      end else begin
        // Position of this byte is the count before it.
        ps_nxt = ps_nxt;
        priority if (ph_nxt == PH_BODY) begin
          rem_nxt = rem_nxt - 1'b1;
          if (rem_nxt == '0) begin ph_nxt = PH_DONE; hk_nxt = ST_OK; end
        end else if (cr_nxt) begin
          cr_nxt = 1'b0;
          if (!item.is_lf) begin
            ph_nxt = PH_DONE; hk_nxt = ST_BAD;
          end else begin
            unique case (ph_nxt)
              PH_VERSION: begin
                if (mi_nxt == 4'd8) begin ph_nxt = PH_HNAME; mi_nxt = '0; hk_nxt = '0; end
                else begin ph_nxt = PH_DONE; hk_nxt = ST_BAD; end
              end
              PH_METHOD, PH_GAP1, PH_PREFIX, PH_HOST, PH_PATH, PH_GAP2, PH_FAIL: begin
                ph_nxt = PH_DONE; hk_nxt = ST_BAD;
              end
              PH_HNAME: begin
                if (mi_nxt == '0) begin
                  if (len_nxt != '0) begin rem_nxt = len_nxt; ph_nxt = PH_BODY; end
                  else begin ph_nxt = PH_DONE; hk_nxt = ST_OK; end
                end else begin
                  ph_nxt = PH_HNAME; mi_nxt = '0; hk_nxt = '0;
                end
              end
              PH_CVAL: begin
                if (mi_nxt == 4'd10) keep_nxt = 1'b1;
                ph_nxt = PH_HNAME; mi_nxt = '0; hk_nxt = '0;
              end
              default: begin ph_nxt = PH_HNAME; mi_nxt = '0; hk_nxt = '0; end
            endcase
          end
        end else if (item.is_cr) begin
          cr_nxt = 1'b1;
        end else if (item.is_lf) begin
          ph_nxt = PH_DONE; hk_nxt = ST_BAD;
        end else begin
          unique case (ph_nxt)
            PH_METHOD: begin
              if (item.is_gap) ph_nxt = (mi_nxt == 4'd3) ? PH_GAP1 : PH_FAIL;
              else if (mi_nxt < 4'd3 && lc == kw_get_chr(mi_nxt)) mi_nxt = mi_nxt + 1'b1;
              else ph_nxt = PH_FAIL;
            end
            PH_GAP1: begin
              if (!item.is_gap) begin
                if (c == "/") begin ps_nxt = seen_r; pz_nxt = 16'd1; ph_nxt = PH_PATH; end
                else if (lc == "h") begin mi_nxt = 4'd1; ph_nxt = PH_PREFIX; end
                else ph_nxt = PH_FAIL;
              end
            end
            PH_PREFIX: begin
              if (mi_nxt < 4'd7 && lc == kw_scheme_chr(mi_nxt)) begin
                mi_nxt = mi_nxt + 1'b1;
                if (mi_nxt == 4'd7) ph_nxt = PH_HOST;
              end else ph_nxt = PH_FAIL;
            end
            PH_HOST: begin
              if (item.is_gap) ph_nxt = PH_FAIL;
              else if (c == "/") begin ps_nxt = seen_r; pz_nxt = 16'd1; ph_nxt = PH_PATH; end
            end
            PH_PATH: begin
              if (item.is_gap) ph_nxt = PH_GAP2;
              else if (pz_nxt != 16'hFFFF) pz_nxt = pz_nxt + 1'b1;
            end
            PH_GAP2, PH_VERSION: begin
              if (!(ph_nxt == PH_GAP2 && item.is_gap)) begin
                k = (ph_nxt == PH_GAP2) ? 4'd0 : mi_nxt;
                if (k < 4'd8 && lc == kw_ver_chr(k)) begin
                  mi_nxt = k + 1'b1; ph_nxt = PH_VERSION;
                end else begin
                  mi_nxt = k; ph_nxt = PH_FAIL;
                end
              end
            end
            PH_HNAME: begin
              if (mi_nxt == '0) begin
                if (lc == "c") begin hk_nxt = 2'd1; mi_nxt = 4'd1; end
                else if (lc == "h") begin hk_nxt = 2'd3; mi_nxt = 4'd1; end
                else ph_nxt = PH_HSKIP;
              end else begin
                if (hk_nxt == 2'd1 && mi_nxt == 4'd3 && lc == "t") hk_nxt = 2'd2;
                hl = hdr_len(hk_nxt);
                if ({1'b0, mi_nxt} < hl && lc == hdr_chr(hk_nxt, mi_nxt)) begin
                  mi_nxt = mi_nxt + 1'b1;
                  if ({1'b0, mi_nxt} == hl) begin
                    if (hk_nxt == 2'd1) begin ph_nxt = PH_CGAP; mi_nxt = '0; end
                    else if (hk_nxt == 2'd2) begin ph_nxt = PH_LGAP; len_nxt = '0; end
                    else ph_nxt = PH_HSKIP;
                  end
                end else ph_nxt = PH_HSKIP;
              end
            end
            PH_CGAP, PH_CVAL: begin
              if (!(ph_nxt == PH_CGAP && item.is_gap)) begin
                k = (ph_nxt == PH_CGAP) ? 4'd0 : mi_nxt;
                if (k < 4'd10 && lc == kw_keep_chr(k)) begin
                  mi_nxt = k + 1'b1; ph_nxt = PH_CVAL;
                end else begin
                  mi_nxt = k; ph_nxt = PH_HSKIP;
                end
              end
            end
            PH_LGAP, PH_LDIG: begin
              if (ph_nxt == PH_LGAP && (item.is_gap || c == 8'h0B || c == 8'h0C)) begin
                ph_nxt = PH_LGAP;
              end else if (ph_nxt == PH_LGAP && c == "+") begin
                ph_nxt = PH_LDIG;
              end else if (item.is_digit) begin
                ph_nxt = PH_LDIG;
                if (len_nxt > LenTen || (len_nxt == LenTen && dig > LenRem))
                  len_nxt = LenLimit;
                else len_nxt = len_x10[LenW-1:0];
              end else ph_nxt = PH_HSKIP;
            end
            default: ;
          endcase
        end
        seen_nxt = seen_r + 1'b1;
        if (item.restart) seen_nxt = 16'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r <= PH_METHOD; mi_r <= '0; hk_r <= '0; cr_r <= 1'b0; seen_r <= '0;
      len_r <= '0; rem_r <= '0; keep_r <= 1'b0; ps_r <= '0; pz_r <= '0;
      res_valid_r <= 1'b0;
    end else begin
      if (res_ready) res_valid_r <= 1'b0;
      if (take) begin
        ph_r <= ph_nxt; mi_r <= mi_nxt; hk_r <= hk_nxt; cr_r <= cr_nxt;
        seen_r <= seen_nxt; len_r <= len_nxt; rem_r <= rem_nxt; keep_r <= keep_nxt;
        ps_r <= ps_nxt; pz_r <= pz_nxt;
        res_valid_r <= 1'b1;
      end
    end
    if (take) begin
      st_r <= (ph_nxt == PH_DONE) ? hk_nxt : ST_MORE;
      kp_r <= keep_nxt;
      lo_r <= len_nxt;
      of_r <= ps_nxt;
      sz_r <= pz_nxt;
    end
  end

  assign res_valid  = res_valid_r;
  assign res_status = st_r;
  assign res_keep   = kp_r;
  assign res_length = OutLenW'(lo_r);
  assign res_offset = of_r;
  assign res_size   = sz_r;

endmodule

FILE: hw/rtl/http_request_header_parser_unit.sv
// Channel  Direction  Payload
// in_      slave      tdata rx_byte[7:0]; tuser restart
// out_     master     tdata status, keep_alive, body_length, url_offset, url_length
// cfg_     slave      data max_request_bytes[15:0]
//
// One byte per cycle is taken unless the result output stalls; the back-end state update
// sets it. An accepted input passes the front register, the queue and the result register
// before its result appears. Reset is synchronous, active low, and restores the 2048-byte
// limit. Either side may stall; the queue absorbs two items.
module http_request_header_parser_unit
  import hrp_pkg::*;
#(
  parameter int unsigned REQUEST_BUFFER_BYTES = 2048,
  parameter int unsigned LENGTH_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // rx_byte[7:0]
  input  logic        s_axis_tuser,  // restart
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // status[1:0], keep_alive[2], body_length[34:3], url_offset[50:35], url_length[66:51]
  output logic [71:0] m_axis_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);

`include "http_request_header_parser_unit_macros.svh"

  logic [PosW-1:0] max_r;
  logic            fv, fr, qv, qr;
  byte_item_t      fi, qi;
  logic [1:0]          st;
  logic                kp;
  logic [OutLenW-1:0]  bl;
  logic [PosW-1:0]     uo, ul;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) max_r <= 16'd2048;
    else if (cfg_valid) max_r <= cfg_data;
  end

  hrp_front u_front (
    .clk, .rst_n, .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .in_ch(s_axis_tdata), .in_restart(s_axis_tuser),
    .item_valid(fv), .item_ready(fr), .item(fi)
  );

  hrp_queue u_queue (
    .clk, .rst_n, .wr_valid(fv), .wr_ready(fr), .wr_item(fi),
    .rd_valid(qv), .rd_ready(qr), .rd_item(qi)
  );

  hrp_back #(.REQUEST_BUFFER_BYTES(REQUEST_BUFFER_BYTES), .LENGTH_BITS(LENGTH_BITS)) u_back (
    .clk, .rst_n, .max_bytes(max_r), .item_valid(qv), .item_ready(qr), .item(qi),
    .res_valid(m_axis_tvalid), .res_ready(m_axis_tready), .res_status(st),
    .res_keep(kp), .res_length(bl), .res_offset(uo), .res_size(ul)
  );

  assign m_axis_tdata = {5'd0, ul, uo, bl, kp, st};

  `HRP_ASSERT_NEXT(a_out_holds, m_axis_tvalid && !m_axis_tready,
      m_axis_tvalid && $stable(m_axis_tdata), "result changed while stalled")
  `HRP_ASSERT_IMPL(a_pad_zero, m_axis_tvalid, m_axis_tdata[71:67] == 5'd0,
      "tdata padding not zero")
  `HRP_ASSERT_IMPL(a_url_len, m_axis_tvalid && m_axis_tdata[66:51] == 16'd0,
      m_axis_tdata[50:35] == 16'd0, "url offset set without a path")

endmodule
